FILE: sv/aarm_pkg.sv
// shared types, constants and helper functions of the axis-angle rotation matrix block
package aarm_pkg;

    localparam int AXIS_BITS  = 16;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;

    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = FRAC_BITS + 1;
    localparam int TRIG_CELLS = 12;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // series coefficients of the k-th power of the quarter-turn angle, q30
    localparam longint unsigned TRIG_A1  = ((Q30_ONE * HALF_PI_Q30) >> 30) / 1;
    localparam longint unsigned TRIG_A2  = ((TRIG_A1 * HALF_PI_Q30) >> 30) / 2;
    localparam longint unsigned TRIG_A3  = ((TRIG_A2 * HALF_PI_Q30) >> 30) / 3;
    localparam longint unsigned TRIG_A4  = ((TRIG_A3 * HALF_PI_Q30) >> 30) / 4;
    localparam longint unsigned TRIG_A5  = ((TRIG_A4 * HALF_PI_Q30) >> 30) / 5;
    localparam longint unsigned TRIG_A6  = ((TRIG_A5 * HALF_PI_Q30) >> 30) / 6;
    localparam longint unsigned TRIG_A7  = ((TRIG_A6 * HALF_PI_Q30) >> 30) / 7;
    localparam longint unsigned TRIG_A8  = ((TRIG_A7 * HALF_PI_Q30) >> 30) / 8;
    localparam longint unsigned TRIG_A9  = ((TRIG_A8 * HALF_PI_Q30) >> 30) / 9;
    localparam longint unsigned TRIG_A10 = ((TRIG_A9 * HALF_PI_Q30) >> 30) / 10;
    localparam longint unsigned TRIG_A11 = ((TRIG_A10 * HALF_PI_Q30) >> 30) / 11;
    localparam longint unsigned TRIG_A12 = ((TRIG_A11 * HALF_PI_Q30) >> 30) / 12;

    localparam logic [11:0][30:0] TRIG_COEF = {
        31'(TRIG_A12), 31'(TRIG_A11), 31'(TRIG_A10), 31'(TRIG_A9),
        31'(TRIG_A8),  31'(TRIG_A7),  31'(TRIG_A6),  31'(TRIG_A5),
        31'(TRIG_A4),  31'(TRIG_A3),  31'(TRIG_A2),  31'(TRIG_A1)
    };

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    typedef struct packed {
        logic [2:0]  neg;
        logic        zero;
        logic [15:0] ang;
    } side_t;

    typedef struct packed {
        logic [63:0]      rem;
        logic [63:0]      res;
        logic [2:0][30:0] m;
        side_t            sd;
    } sq_t;

    typedef struct packed {
        logic [2:0][46:0] rem;
        logic [2:0][14:0] quo;
        logic [31:0]      q;
        side_t            sd;
    } dv_t;

    typedef struct packed {
        logic [30:0]        p;
        logic signed [33:0] acc_s;
        logic signed [33:0] acc_c;
        logic [29:0]        f;
        logic [1:0]         quad;
        logic [2:0][15:0]   u;
    } tg_t;

    // Q1.14 product back to Q1.14, rounding half away from zero
    function automatic logic signed [19:0] rnd_q(input logic signed [33:0] v);
        logic [33:0] m;
        logic [33:0] r;
        m = v[33] ? 34'(-v) : 34'(v);
        r = (m + (34'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[33] ? -$signed(20'(r)) : $signed(20'(r));
    endfunction

    function automatic logic signed [15:0] sat_q(input logic signed [19:0] v);
        if (v > 20'sd16384) begin
            return 16'sd16384;
        end else if (v < -20'sd16384) begin
            return -16'sd16384;
        end
        return 16'(v);
    endfunction

endpackage

FILE: sv/axis_angle_rotation_matrix_top.sv
// top level of the axis-angle (rodrigues) rotation matrix pipeline
//
// input channel: s_valid/s_ready with axis components s_axis_x/y/z (signed, any
// scale) and binary angle s_angle (65536 per turn)
// result channel: m_valid/m_ready with the nine q1.14 elements m_r00 .. m_r22
// of the 3x3 rotation matrix, each saturated to +-16384
// one beat in gives exactly one result beat, in order
// throughput: one beat per cycle while no result is stalled at the output; the
// pipeline is 67 register stages deep
// depth is set by the 32 square root cells, 15 divider cells and 12 power series
// cells, plus normalise, divider and series setup, quadrant, product and output stages
// the whole pipeline advances when the output register is empty or being taken;
// when the receiver stalls with a result waiting, s_ready drops and all stages hold
// reset clears every stage's valid flag; no beat is lost or repeated
module axis_angle_rotation_matrix_top
    import aarm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_axis_x,
    input  logic [15:0] s_axis_y,
    input  logic [15:0] s_axis_z,
    input  logic [15:0] s_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_r00,
    output logic [15:0] m_r01,
    output logic [15:0] m_r02,
    output logic [15:0] m_r10,
    output logic [15:0] m_r11,
    output logic [15:0] m_r12,
    output logic [15:0] m_r20,
    output logic [15:0] m_r21,
    output logic [15:0] m_r22
);

    logic en;

    // stage 1: magnitudes and normalising shift
    logic [2:0][15:0] ax;
    logic [2:0][16:0] mag_w;
    logic [16:0]      mx_w;
    logic [4:0]       msb_w;
    logic             n1_v_reg;
    logic [2:0][16:0] n1_mag_reg;
    logic [4:0]       n1_sh_reg;
    side_t            n1_sd_reg;

    // stage 2 and chains
    logic        n2_v_reg;
    sq_t         n2_d_reg;
    logic [35:0] sumsq_w;
    sq_t         n2_d_next;

    logic [SQRT_CELLS:0] sq_v;
    sq_t                 sq_d [SQRT_CELLS+1];
    logic [DIV_CELLS:0]  dv_v;
    dv_t                 dv_d [DIV_CELLS+1];
    logic [TRIG_CELLS:0] tg_v;
    tg_t                 tg_d [TRIG_CELLS+1];

    logic        dp_v_reg;
    dv_t         dp_d_reg;
    dv_t         dp_d_next;
    logic [31:0] root_w;

    logic        tp_v_reg;
    tg_t         tp_d_reg;
    tg_t         tp_d_next;
    dv_t         dv_last;

    // post, product and output stages
    logic signed [33:0] cls_w;
    logic signed [33:0] clc_w;
    logic [14:0]        s0_w;
    logic [14:0]        c0_w;
    logic signed [15:0] s_next;
    logic signed [15:0] c_next;
    logic               po_v_reg;
    logic signed [15:0] po_s_reg;
    logic signed [15:0] po_c_reg;
    logic [2:0][15:0]   po_u_reg;

    logic signed [16:0] t_w;
    logic signed [33:0] pt_w [3];
    logic signed [33:0] ps_w [3];
    logic               pa_v_reg;
    logic signed [17:0] pa_t_reg [3];
    logic signed [17:0] pa_s_reg [3];
    logic signed [15:0] pa_c_reg;
    logic [2:0][15:0]   pa_u_reg;

    logic signed [33:0] pxy_w, pxz_w, pyz_w, pxx_w, pyy_w, pzz_w;
    logic               pb_v_reg;
    logic signed [19:0] pb_xy_reg, pb_xz_reg, pb_yz_reg;
    logic signed [19:0] pb_xx_reg, pb_yy_reg, pb_zz_reg;
    logic signed [17:0] pb_s_reg [3];
    logic signed [15:0] pb_c_reg;

    logic               out_v_reg;
    logic [8:0][15:0]   out_reg;
    logic [8:0][15:0]   out_next;

    assign en      = m_ready | ~out_v_reg;
    assign s_ready = en;

    assign ax = {s_axis_z, s_axis_y, s_axis_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_w[i] = ax[i][15] ? 17'(~{1'b1, ax[i]} + 17'd1) : {1'b0, ax[i]};
        end
        mx_w = mag_w[0];
        if (mag_w[1] > mx_w) mx_w = mag_w[1];
        if (mag_w[2] > mx_w) mx_w = mag_w[2];
        msb_w = 5'd0;
        for (int b = 0; b < 17; b++) begin
            if (mx_w[b]) msb_w = 5'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_v_reg <= 1'b0;
        end else if (en) begin
            n1_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_mag_reg   <= mag_w;
            n1_sh_reg    <= 5'd30 - msb_w;
            n1_sd_reg.neg  <= {s_axis_z[15], s_axis_y[15], s_axis_x[15]};
            n1_sd_reg.zero <= (mx_w == 17'd0);
            n1_sd_reg.ang  <= s_angle;
        end
    end

    always_comb begin
        sumsq_w = 36'(n1_mag_reg[0]) * 36'(n1_mag_reg[0])
                + 36'(n1_mag_reg[1]) * 36'(n1_mag_reg[1])
                + 36'(n1_mag_reg[2]) * 36'(n1_mag_reg[2]);
        n2_d_next.rem = 64'(sumsq_w) << {n1_sh_reg, 1'b0};
        n2_d_next.res = 64'd0;
        for (int i = 0; i < 3; i++) begin
            n2_d_next.m[i] = 31'({14'd0, n1_mag_reg[i]} << n1_sh_reg);
        end
        n2_d_next.sd = n1_sd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_v_reg <= 1'b0;
        end else if (en) begin
            n2_v_reg <= n1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_d_reg <= n2_d_next;
        end
    end

    assign sq_v[0] = n2_v_reg;
    assign sq_d[0] = n2_d_reg;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        aarm_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (5'(g)),
            .v_in    (sq_v[g]),
            .d_in    (sq_d[g]),
            .v_out   (sq_v[g+1]),
            .d_out   (sq_d[g+1])
        );
    end

    always_comb begin
        root_w        = sq_d[SQRT_CELLS].res[31:0];
        dp_d_next.q   = root_w;
        dp_d_next.sd  = sq_d[SQRT_CELLS].sd;
        for (int i = 0; i < 3; i++) begin
            dp_d_next.rem[i] = (47'(sq_d[SQRT_CELLS].m[i]) << FRAC_BITS)
                             + 47'(root_w >> 1);
            dp_d_next.quo[i] = 15'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_v_reg <= 1'b0;
        end else if (en) begin
            dp_v_reg <= sq_v[SQRT_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_d_reg <= dp_d_next;
        end
    end

    assign dv_v[0] = dp_v_reg;
    assign dv_d[0] = dp_d_reg;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        aarm_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (4'(g)),
            .v_in    (dv_v[g]),
            .d_in    (dv_d[g]),
            .v_out   (dv_v[g+1]),
            .d_out   (dv_d[g+1])
        );
    end

    assign dv_last = dv_d[DIV_CELLS];

    always_comb begin
        tp_d_next.p     = 31'({dv_last.sd.ang[13:0], 16'd0});
        tp_d_next.f     = {dv_last.sd.ang[13:0], 16'd0};
        tp_d_next.quad  = dv_last.sd.ang[15:14];
        tp_d_next.acc_s = 34'sd0;
        tp_d_next.acc_c = 34'(Q30_ONE);
        for (int i = 0; i < 3; i++) begin
            if (dv_last.sd.zero) begin
                tp_d_next.u[i] = 16'd0;
            end else if (dv_last.sd.neg[i]) begin
                tp_d_next.u[i] = 16'd0 - {1'b0, dv_last.quo[i]};
            end else begin
                tp_d_next.u[i] = {1'b0, dv_last.quo[i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_v_reg <= 1'b0;
        end else if (en) begin
            tp_v_reg <= dv_v[DIV_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tp_d_reg <= tp_d_next;
        end
    end

    assign tg_v[0] = tp_v_reg;
    assign tg_d[0] = tp_d_reg;

    for (genvar g = 0; g < TRIG_CELLS; g++) begin : g_trig
        localparam logic [30:0] COEF = TRIG_COEF[g];
        localparam logic        IS_SIN = ((g + 1) % 2) == 1;
        localparam logic        IS_NEG = (((g + 1) / 2) % 2) == 1;
        aarm_trig_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .coef    (COEF),
            .is_sin  (IS_SIN),
            .is_neg  (IS_NEG),
            .v_in    (tg_v[g]),
            .d_in    (tg_d[g]),
            .v_out   (tg_v[g+1]),
            .d_out   (tg_d[g+1])
        );
    end

    // clamp, round to q1.14 and unfold the quadrant
    always_comb begin
        cls_w = tg_d[TRIG_CELLS].acc_s;
        clc_w = tg_d[TRIG_CELLS].acc_c;
        if (cls_w < 0) cls_w = 34'sd0;
        if (cls_w > $signed(34'(Q30_ONE))) cls_w = 34'(Q30_ONE);
        if (clc_w < 0) clc_w = 34'sd0;
        if (clc_w > $signed(34'(Q30_ONE))) clc_w = 34'(Q30_ONE);
        s0_w = 15'((cls_w + 34'sd32768) >>> 16);
        c0_w = 15'((clc_w + 34'sd32768) >>> 16);
        case (tg_d[TRIG_CELLS].quad)
            QUAD_FIRST: begin
                s_next = $signed({1'b0, s0_w});
                c_next = $signed({1'b0, c0_w});
            end
            QUAD_SECOND: begin
                s_next = $signed({1'b0, c0_w});
                c_next = -$signed({1'b0, s0_w});
            end
            QUAD_THIRD: begin
                s_next = -$signed({1'b0, s0_w});
                c_next = -$signed({1'b0, c0_w});
            end
            default: begin
                s_next = -$signed({1'b0, c0_w});
                c_next = $signed({1'b0, s0_w});
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            po_v_reg <= 1'b0;
        end else if (en) begin
            po_v_reg <= tg_v[TRIG_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            po_s_reg <= s_next;
            po_c_reg <= c_next;
            po_u_reg <= tg_d[TRIG_CELLS].u;
        end
    end

    // first products: t*u and s*u
    always_comb begin
        t_w = 17'sd16384 - 17'(po_c_reg);
        for (int i = 0; i < 3; i++) begin
            pt_w[i] = t_w * $signed(po_u_reg[i]);
            ps_w[i] = po_s_reg * $signed(po_u_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_v_reg <= 1'b0;
        end else if (en) begin
            pa_v_reg <= po_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_t_reg[i] <= 18'(rnd_q(pt_w[i]));
                pa_s_reg[i] <= 18'(rnd_q(ps_w[i]));
            end
            pa_c_reg <= po_c_reg;
            pa_u_reg <= po_u_reg;
        end
    end

    // second products: t*u*u
    always_comb begin
        pxy_w = pa_t_reg[0] * $signed(pa_u_reg[1]);
        pxz_w = pa_t_reg[0] * $signed(pa_u_reg[2]);
        pyz_w = pa_t_reg[1] * $signed(pa_u_reg[2]);
        pxx_w = pa_t_reg[0] * $signed(pa_u_reg[0]);
        pyy_w = pa_t_reg[1] * $signed(pa_u_reg[1]);
        pzz_w = pa_t_reg[2] * $signed(pa_u_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_v_reg <= 1'b0;
        end else if (en) begin
            pb_v_reg <= pa_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pb_xy_reg <= rnd_q(pxy_w);
            pb_xz_reg <= rnd_q(pxz_w);
            pb_yz_reg <= rnd_q(pyz_w);
            pb_xx_reg <= rnd_q(pxx_w);
            pb_yy_reg <= rnd_q(pyy_w);
            pb_zz_reg <= rnd_q(pzz_w);
            pb_s_reg  <= pa_s_reg;
            pb_c_reg  <= pa_c_reg;
        end
    end

    always_comb begin
        out_next[0] = sat_q(20'(pb_c_reg) + pb_xx_reg);
        out_next[1] = sat_q(pb_xy_reg + 20'(pb_s_reg[2]));
        out_next[2] = sat_q(pb_xz_reg - 20'(pb_s_reg[1]));
        out_next[3] = sat_q(pb_xy_reg - 20'(pb_s_reg[2]));
        out_next[4] = sat_q(20'(pb_c_reg) + pb_yy_reg);
        out_next[5] = sat_q(pb_yz_reg + 20'(pb_s_reg[0]));
        out_next[6] = sat_q(pb_xz_reg + 20'(pb_s_reg[1]));
        out_next[7] = sat_q(pb_yz_reg - 20'(pb_s_reg[0]));
        out_next[8] = sat_q(20'(pb_c_reg) + pb_zz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= pb_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_r00   = out_reg[0];
    assign m_r01   = out_reg[1];
    assign m_r02   = out_reg[2];
    assign m_r10   = out_reg[3];
    assign m_r11   = out_reg[4];
    assign m_r12   = out_reg[5];
    assign m_r20   = out_reg[6];
    assign m_r21   = out_reg[7];
    assign m_r22   = out_reg[8];

endmodule

FILE: sv/aarm_sqrt_cell.sv
// one digit step of the pipelined integer square root
module aarm_sqrt_cell
    import aarm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [4:0] idx,
    input  logic       v_in,
    input  sq_t        d_in,
    output logic       v_out,
    output sq_t        d_out
);

    logic        v_reg;
    sq_t         d_reg;
    sq_t         d_next;
    logic [63:0] bit_w;
    logic [64:0] trial;

    always_comb begin
        bit_w  = 64'd1 << (6'd62 - {idx, 1'b0});
        trial  = {1'b0, d_in.res} + {1'b0, bit_w};
        d_next = d_in;
        if ({1'b0, d_in.rem} >= trial) begin
            d_next.rem = d_in.rem - trial[63:0];
            d_next.res = (d_in.res >> 1) + bit_w;
        end else begin
            d_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;

endmodule

FILE: sv/aarm_div_cell.sv
// one quotient bit of the three component divisions
module aarm_div_cell
    import aarm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [3:0] idx,
    input  logic       v_in,
    input  dv_t        d_in,
    output logic       v_out,
    output dv_t        d_out
);

    logic        v_reg;
    dv_t         d_reg;
    dv_t         d_next;
    logic [3:0]  pos;
    logic [46:0] dsr;

    always_comb begin
        pos    = 4'(DIV_CELLS - 1) - idx;
        dsr    = 47'(d_in.q) << pos;
        d_next = d_in;
        for (int i = 0; i < 3; i++) begin
            if (d_in.rem[i] >= dsr) begin
                d_next.rem[i]      = d_in.rem[i] - dsr;
                d_next.quo[i][pos] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;

endmodule

FILE: sv/aarm_trig_cell.sv
// one term of the sine and cosine power series
module aarm_trig_cell
    import aarm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [30:0] coef,
    input  logic        is_sin,
    input  logic        is_neg,
    input  logic        v_in,
    input  tg_t         d_in,
    output logic        v_out,
    output tg_t         d_out
);

    logic               v_reg;
    tg_t                d_reg;
    tg_t                d_next;
    logic [60:0]        pf;
    logic [61:0]        cp;
    logic signed [33:0] term;

    always_comb begin
        pf     = 61'(d_in.p) * 61'(d_in.f);
        cp     = 62'(coef) * 62'(d_in.p);
        term   = is_neg ? -$signed(34'(cp >> 30)) : $signed(34'(cp >> 30));
        d_next = d_in;
        d_next.p = 31'(pf >> 30);
        if (is_sin) begin
            d_next.acc_s = d_in.acc_s + term;
        end else begin
            d_next.acc_c = d_in.acc_c + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;

endmodule

FILE: sv/aarm_checker.sv
// port-level assertions for the rotation matrix block, bound to its top level
module aarm_checker
    import aarm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_r00,
    input logic [15:0] m_r11,
    input logic [15:0] m_r22
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_stall_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_r00) && $stable(m_r11) && $stable(m_r22))
        else $error("stalled result changed");

    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("input ready does not follow output side");

    a_diag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_r00) <= 16'sd16384) && ($signed(m_r00) >= -16'sd16384)
                 && ($signed(m_r11) <= 16'sd16384) && ($signed(m_r11) >= -16'sd16384))
        else $error("diagonal element out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind axis_angle_rotation_matrix_top aarm_checker u_aarm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_r00   (m_r00),
    .m_r11   (m_r11),
    .m_r22   (m_r22)
);

FILE: dv/axis_angle_rotation_matrix_checker.sv
// checker for the rotation matrix block: predicts each result beat and compares it
module axis_angle_rotation_matrix_checker
    import aarm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_axis_x,
    input  logic [15:0] s_axis_y,
    input  logic [15:0] s_axis_z,
    input  logic [15:0] s_angle,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_r00,
    input  logic [15:0] m_r01,
    input  logic [15:0] m_r02,
    input  logic [15:0] m_r10,
    input  logic [15:0] m_r11,
    input  logic [15:0] m_r12,
    input  logic [15:0] m_r20,
    input  logic [15:0] m_r21,
    input  logic [15:0] m_r22,
    output int          fail_count,
    output int          pending_count
);

    typedef logic [8:0][15:0] matrix_t;

    matrix_t matrix_q[$];

    function automatic longint round_prod(input longint a, input longint b);
        longint p;
        longint unsigned m;
        p = a * b;
        m = p < 0 ? -p : p;
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_one(input longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) begin
            return one;
        end else if (v < -one) begin
            return -one;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic matrix_t rotation_of(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] z, input logic [15:0] ang);
        longint ax[3];
        longint u[3];
        longint unsigned m[3];
        longint unsigned mx, n, q, v, f, a, p;
        longint acc_s, acc_c, term, s0, c0, s, c, t, tx, ty, tz, txy, txz, tyz, sx, sy, sz;
        longint res[9];
        logic [1:0] quad;
        matrix_t r;
        ax[0] = longint'($signed(x));
        ax[1] = longint'($signed(y));
        ax[2] = longint'($signed(z));
        for (int i = 0; i < 3; i++) begin
            m[i] = ax[i] < 0 ? -ax[i] : ax[i];
            u[i] = 0;
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx != 0) begin
            while (mx < (64'd1 << 30)) begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) m[i] <<= 1;
            end
            n = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            q = int_sqrt(n);
            for (int i = 0; i < 3; i++) begin
                v = ((m[i] << FRAC_BITS) + (q >> 1)) / q;
                u[i] = ax[i] < 0 ? -longint'(v) : longint'(v);
            end
        end
        quad = ang[15:14];
        f = longint'(ang[13:0]) << 16;
        a = Q30_ONE;
        p = Q30_ONE;
        acc_s = 0;
        acc_c = 0;
        for (int k = 0; k <= 12; k++) begin
            if (k > 0) begin
                a = ((a * HALF_PI_Q30) >> 30) / longint'(k);
                p = (p * f) >> 30;
            end
            term = longint'((a * p) >> 30);
            if (((k >> 1) & 1) != 0) term = -term;
            if ((k & 1) != 0) acc_s += term;
            else acc_c += term;
        end
        if (acc_s < 0) acc_s = 0;
        if (acc_s > longint'(Q30_ONE)) acc_s = Q30_ONE;
        if (acc_c < 0) acc_c = 0;
        if (acc_c > longint'(Q30_ONE)) acc_c = Q30_ONE;
        s0 = (acc_s + (longint'(1) << 15)) >>> 16;
        c0 = (acc_c + (longint'(1) << 15)) >>> 16;
        case (quad)
            QUAD_FIRST: begin
                s = s0; c = c0;
            end
            QUAD_SECOND: begin
                s = c0; c = -s0;
            end
            QUAD_THIRD: begin
                s = -s0; c = -c0;
            end
            default: begin
                s = -c0; c = s0;
            end
        endcase
        t = (longint'(1) << FRAC_BITS) - c;
        tx = round_prod(t, u[0]);
        ty = round_prod(t, u[1]);
        tz = round_prod(t, u[2]);
        txy = round_prod(tx, u[1]);
        txz = round_prod(tx, u[2]);
        tyz = round_prod(ty, u[2]);
        sx = round_prod(s, u[0]);
        sy = round_prod(s, u[1]);
        sz = round_prod(s, u[2]);
        res[0] = c + round_prod(tx, u[0]);
        res[1] = txy + sz;
        res[2] = txz - sy;
        res[3] = txy - sz;
        res[4] = c + round_prod(ty, u[1]);
        res[5] = tyz + sx;
        res[6] = txz + sy;
        res[7] = tyz - sx;
        res[8] = c + round_prod(tz, u[2]);
        for (int i = 0; i < 9; i++) r[i] = 16'(clamp_one(res[i]));
        return r;
    endfunction

    assign pending_count = matrix_q.size();

    always @(posedge aclk) begin
        matrix_t got;
        matrix_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                matrix_q.push_back(rotation_of(s_axis_x, s_axis_y, s_axis_z, s_angle));
            end
            if (m_valid && m_ready) begin
                got = {m_r22, m_r21, m_r20, m_r12, m_r11, m_r10, m_r02, m_r01, m_r00};
                if (matrix_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = matrix_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            for (int i = 0; i < 9; i++) begin
                                if (got[i] !== want[i]) begin
                                    $display("element %0d: expected %0d got %0d", i,
                                             $signed(want[i]), $signed(got[i]));
                                end
                            end
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/axis_angle_rotation_matrix_top_tb.sv
// testbench top: drives axis-angle beats, stalls the result side and gives the verdict
module axis_angle_rotation_matrix_top_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_axis_x = '0;
    logic [15:0] s_axis_y = '0;
    logic [15:0] s_axis_z = '0;
    logic [15:0] s_angle = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22;
    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          hold_result = 1'b0;

    localparam int IDLE_LIMIT = 5000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    axis_angle_rotation_matrix_top u_top (.*);

    axis_angle_rotation_matrix_checker u_checker (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [15:0] a);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_axis_x <= x;
        s_axis_y <= y;
        s_axis_z <= z;
        s_angle <= a;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random back-pressure, or a long hold when asked
    always @(posedge aclk) begin
        if (hold_result) begin
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("axis_angle_rotation_matrix_top_tb failed");
            $finish;
        end
    end

    initial begin
        logic [15:0] dir_axis[9][3];
        logic [15:0] dir_ang[9];
        dir_axis = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'h0001, 16'h0000, 16'h0000},
                     '{16'h0000, 16'h0001, 16'h0000}, '{16'h0000, 16'h0000, 16'h4000},
                     '{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
                     '{16'h7fff, 16'h8000, 16'h0001}, '{16'hffff, 16'h0000, 16'h0000},
                     '{16'h0003, 16'hfffc, 16'h0000}};
        dir_ang = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h3fff,
                    16'h2000, 16'h0001, 16'h5555};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 9; i++) begin
            for (int j = 0; j < 2; j++) begin
                send_beat(dir_axis[i][0], dir_axis[i][1], dir_axis[i][2],
                          j == 0 ? dir_ang[i] : 16'($urandom));
            end
        end
        // long receiver hold while the sender keeps offering beats
        hold_result <= 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_result <= 1'b0;
            end
            begin
                for (int i = 0; i < 120; i++) begin
                    s_valid <= 1'b1;
                    s_axis_x <= rand_comp();
                    s_axis_y <= rand_comp();
                    s_axis_z <= rand_comp();
                    s_angle <= 16'($urandom);
                    do @(posedge aclk); while (!s_ready);
                end
                s_valid <= 1'b0;
            end
        join
        // sender pause until everything has drained
        do @(posedge aclk); while (pending_count != 0);
        for (int i = 0; i < 580; i++) begin
            send_beat(rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("axis_angle_rotation_matrix_top_tb passed");
        end else begin
            $display("axis_angle_rotation_matrix_top_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/aarm_pkg.sv
sv/aarm_sqrt_cell.sv
sv/aarm_div_cell.sv
sv/aarm_trig_cell.sv
sv/axis_angle_rotation_matrix_top.sv
sv/aarm_checker.sv
dv/axis_angle_rotation_matrix_checker.sv
dv/axis_angle_rotation_matrix_top_tb.sv
